// File: sv/lavm_pkg.sv
// Shared constants and codes for the look-at view matrix core.
// Used by lavm_norm and look_at_view_matrix_core; depends on nothing.
`default_nettype none
package lavm_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int SCALE_BITS      = 30;
  localparam int NUM_ROWS        = 12;
  localparam logic [3:0] LAST_ROW = 4'(NUM_ROWS - 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DIR = 2'd1,
    ST_ZERO_UP  = 2'd2,
    ST_PARALLEL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_UP_X = 2'd0,
    CFG_UP_Y = 2'd1,
    CFG_UP_Z = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MAT_VIEW    = 2'd0,
    MAT_BB_FULL = 2'd1,
    MAT_BB_Y    = 2'd2
  } matrix_e;

endpackage
`default_nettype wire

// File: sv/lavm_norm.sv
// Pipelined 3-vector normalizer: block scaling, sum of squares, bit-serial
// square root and restoring division, one stage per step. Uses lavm_pkg.
`default_nettype none
module lavm_norm #(
  parameter int IN_W      = 33,
  parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF,
  parameter int TAG_W     = 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic [2:0][IN_W-1:0]                in_vec_i,
  input  logic [TAG_W-1:0]                    in_tag_i,
  output logic                                out_valid_o,
  output logic [2:0][FRAC_BITS+1:0]           unit_o,
  output logic [2:0][lavm_pkg::SCALE_BITS:0]  scaled_o,
  output logic                                zero_o,
  output logic [TAG_W-1:0]                    tag_o
);
  import lavm_pkg::*;

  localparam int SC  = SCALE_BITS;
  localparam int PW  = $clog2(IN_W);
  localparam int SQW = 2 * SC + 2;
  localparam int NSQ = SC + 1;
  localparam int RW  = SC + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = SC + FRAC_BITS + 1;
  localparam int HW  = IN_W + SC - 1;

  // magnitudes
  logic                  va_q;
  logic [2:0][IN_W-1:0]  mga_q;
  logic [2:0]            nga_q;
  logic [TAG_W-1:0]      taga_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      nga_q[i] <= in_vec_i[i][IN_W-1];
      mga_q[i] <= in_vec_i[i][IN_W-1] ? IN_W'(-in_vec_i[i]) : in_vec_i[i];
    end
    taga_q <= in_tag_i;
  end

  // largest magnitude and its leading one
  logic [IN_W-1:0] mx;
  logic [PW-1:0]   msb;

  always_comb begin
    mx  = mga_q[0];
    msb = '0;
    for (int i = 1; i < 3; i++) begin
      if (mga_q[i] > mx) mx = mga_q[i];
    end
    for (int b = 0; b < IN_W; b++) begin
      if (mx[b]) msb = PW'(b);
    end
  end

  logic                  vb_q, zb_q;
  logic [2:0][IN_W-1:0]  mgb_q;
  logic [2:0]            ngb_q;
  logic [PW-1:0]         pb_q;
  logic [TAG_W-1:0]      tagb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else         vb_q <= va_q;
  end

  always_ff @(posedge clk_i) begin
    mgb_q  <= mga_q;
    ngb_q  <= nga_q;
    pb_q   <= msb;
    zb_q   <= (mx == '0);
    tagb_q <= taga_q;
  end

  // scale so the largest magnitude lands in [2^(SC-1), 2^SC)
  logic                vc_q, zc_q;
  logic [2:0][SC-1:0]  cc_q;
  logic [2:0]          ngc_q;
  logic [TAG_W-1:0]    tagc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else         vc_q <= vb_q;
  end

  always_ff @(posedge clk_i) begin : scale_stage
    logic [HW-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh       = {mgb_q[i], {(SC-1){1'b0}}} >> pb_q;
      cc_q[i] <= sh[SC-1:0];
    end
    ngc_q  <= ngb_q;
    zc_q   <= zb_q;
    tagc_q <= tagb_q;
  end

  // squares
  logic                  vd_q, zd_q;
  logic [2:0][2*SC-1:0]  sqd_q;
  logic [2:0][SC-1:0]    cd_q;
  logic [2:0]            ngd_q;
  logic [TAG_W-1:0]      tagd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else         vd_q <= vc_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sqd_q[i] <= (2*SC)'(cc_q[i]) * (2*SC)'(cc_q[i]);
    end
    cd_q   <= cc_q;
    ngd_q  <= ngc_q;
    zd_q   <= zc_q;
    tagd_q <= tagc_q;
  end

  // square root, one result bit per stage
  logic [SQW-1:0]       sn_q   [0:NSQ];
  logic [SQW-1:0]       sr_q   [0:NSQ];
  logic [2:0][SC-1:0]   sc_q   [0:NSQ];
  logic [2:0]           sng_q  [0:NSQ];
  logic                 sz_q   [0:NSQ];
  logic                 sv_q   [0:NSQ];
  logic [TAG_W-1:0]     stag_q [0:NSQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else         sv_q[0] <= vd_q;
  end

  always_ff @(posedge clk_i) begin
    sn_q[0]   <= SQW'(sqd_q[0]) + SQW'(sqd_q[1]) + SQW'(sqd_q[2]);
    sr_q[0]   <= '0;
    sc_q[0]   <= cd_q;
    sng_q[0]  <= ngd_q;
    sz_q[0]   <= zd_q;
    stag_q[0] <= tagd_q;
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (NSQ - 1 - k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[k+1] <= 1'b0;
      else         sv_q[k+1] <= sv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (sn_q[k] >= sr_q[k] + BIT) begin
        sn_q[k+1] <= sn_q[k] - (sr_q[k] + BIT);
        sr_q[k+1] <= (sr_q[k] >> 1) + BIT;
      end else begin
        sn_q[k+1] <= sn_q[k];
        sr_q[k+1] <= sr_q[k] >> 1;
      end
      sc_q[k+1]   <= sc_q[k];
      sng_q[k+1]  <= sng_q[k];
      sz_q[k+1]   <= sz_q[k];
      stag_q[k+1] <= stag_q[k];
    end
  end

  // rounded division of each scaled component by the root
  logic [RW-1:0]        root;
  logic [2:0][NW-1:0]   dn_q   [0:QW];
  logic [2:0][RW-1:0]   drem_q [0:QW];
  logic [2:0][QW-1:0]   dq_q   [0:QW];
  logic [RW-1:0]        dr_q   [0:QW];
  logic [2:0][SC-1:0]   dc_q   [0:QW];
  logic [2:0]           dng_q  [0:QW];
  logic                 dz_q   [0:QW];
  logic                 dv_q   [0:QW];
  logic [TAG_W-1:0]     dtag_q [0:QW];

  assign root = sr_q[NSQ][RW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else         dv_q[0] <= sv_q[NSQ];
  end

  always_ff @(posedge clk_i) begin : div_load
    logic [NW-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num           = (NW'(sc_q[NSQ][i]) << FRAC_BITS) + NW'(root >> 1);
      dn_q[0][i]   <= num;
      drem_q[0][i] <= RW'(num >> (FRAC_BITS + 1));
      dq_q[0][i]   <= '0;
    end
    dr_q[0]   <= root;
    dc_q[0]   <= sc_q[NSQ];
    dng_q[0]  <= sng_q[NSQ];
    dz_q[0]   <= sz_q[NSQ];
    dtag_q[0] <= stag_q[NSQ];
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[j+1] <= 1'b0;
      else         dv_q[j+1] <= dv_q[j];
    end

    always_ff @(posedge clk_i) begin : div_step
      logic [RW:0] t;
      logic        ge;
      for (int i = 0; i < 3; i++) begin
        t  = {drem_q[j][i], dn_q[j][i][FRAC_BITS-j]};
        ge = (t >= {1'b0, dr_q[j]});
        drem_q[j+1][i] <= ge ? RW'(t - {1'b0, dr_q[j]}) : RW'(t);
        dq_q[j+1][i]   <= {dq_q[j][i][QW-2:0], ge};
      end
      dn_q[j+1]   <= dn_q[j];
      dr_q[j+1]   <= dr_q[j];
      dc_q[j+1]   <= dc_q[j];
      dng_q[j+1]  <= dng_q[j];
      dz_q[j+1]   <= dz_q[j];
      dtag_q[j+1] <= dtag_q[j];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_o[i]   = dng_q[QW][i] ? (FRAC_BITS+2)'(-{1'b0, dq_q[QW][i]})
                                 : (FRAC_BITS+2)'({1'b0, dq_q[QW][i]});
      scaled_o[i] = dng_q[QW][i] ? (SC+1)'(-{1'b0, dc_q[QW][i]})
                                 : (SC+1)'({1'b0, dc_q[QW][i]});
    end
  end

  assign out_valid_o = dv_q[QW];
  assign zero_o      = dz_q[QW];
  assign tag_o       = dtag_q[QW];

endmodule
`default_nettype wire

// File: sv/look_at_view_matrix_core.sv
// Look-at view matrix core: Z, X and up normalizers, cross products,
// translations and a twelve-row result sequencer. Uses lavm_pkg, lavm_norm.
//
// The block takes a new eye/target pair only while busy is low: busy is
// raised after each start and spaces the items, because every item leaves
// as twelve rows on the one result port, one row per cycle. Results are
// strobed by valid_o for a single cycle and cannot be held off. From start
// to the first row the data passes the two normalizers in series, each a
// bit-per-stage square root and a bit-per-stage divider. A degenerate
// input (target equal to eye, zero up vector, or up parallel to the view
// direction) gives one row with a nonzero status and last_o set. Write the
// up vector only while idle.
`default_nettype none
module look_at_view_matrix_core #(
  parameter int FRAC_BITS   = lavm_pkg::FRAC_BITS_DEF,
  parameter int COORD_WIDTH = lavm_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,
  input  logic                   start,
  output logic                   busy,
  input  logic [COORD_WIDTH-1:0] eye_x_i,
  input  logic [COORD_WIDTH-1:0] eye_y_i,
  input  logic [COORD_WIDTH-1:0] eye_z_i,
  input  logic [COORD_WIDTH-1:0] target_x_i,
  input  logic [COORD_WIDTH-1:0] target_y_i,
  input  logic [COORD_WIDTH-1:0] target_z_i,
  output logic                   valid_o,
  output logic [COORD_WIDTH-1:0] row_x_o,
  output logic [COORD_WIDTH-1:0] row_y_o,
  output logic [COORD_WIDTH-1:0] row_z_o,
  output logic [COORD_WIDTH-1:0] row_w_o,
  output logic [1:0]             matrix_id_o,
  output logic [1:0]             row_index_o,
  output logic [1:0]             status_o,
  output logic                   last_o
);
  import lavm_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int UW   = FRAC_BITS + 2;
  localparam int SCW  = SCALE_BITS + 1;
  localparam int ZXW  = SCW + UW + 1;
  localparam int SW   = 2 * W + 4;
  localparam int XTW  = 9 * W + 2;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

  function automatic logic [W-1:0] sat_w(input logic signed [SW-1:0] v);
    logic [W-1:0] r;
    if (v > SMAX)      r = SMAX[W-1:0];
    else if (v < SMIN) r = SMIN[W-1:0];
    else               r = v[W-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] rnd_w(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] s;
    s = (v + HALF) >>> FRAC_BITS;
    return sat_w(s);
  endfunction

  localparam logic [W-1:0] ONE = sat_w(SW'(1) <<< FRAC_BITS);

  // up vector registers
  logic [2:0][W-1:0] up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= '0;
      up_q[1] <= W'(1) << FRAC_BITS;
      up_q[2] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UP_X: up_q[0] <= cfg_data_i;
        CFG_UP_Y: up_q[1] <= cfg_data_i;
        CFG_UP_Z: up_q[2] <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // intake spacing
  logic       accept;
  logic [3:0] gap_q;

  assign accept = start && !busy;
  assign busy   = (gap_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          gap_q <= '0;
    else if (accept)      gap_q <= LAST_ROW;
    else if (gap_q != '0) gap_q <= gap_q - 4'd1;
  end

  // direction and up normalizers
  logic [2:0][W:0]    dir;
  logic [2:0][W-1:0]  eye_in, tgt_in;

  assign eye_in = {eye_z_i, eye_y_i, eye_x_i};
  assign tgt_in = {target_z_i, target_y_i, target_x_i};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = (W+1)'($signed({tgt_in[i][W-1], tgt_in[i]}) -
                      $signed({eye_in[i][W-1], eye_in[i]}));
    end
  end

  logic                  z_valid, u_valid, z_zero, u_zero;
  logic [2:0][UW-1:0]    z_unit, u_unit;
  logic [2:0][SCW-1:0]   u_scaled;
  logic [2*W-1:0]        z_tag;
  logic [W-1:0]          u_tag;

  lavm_norm #(.IN_W(W + 1), .FRAC_BITS(FRAC_BITS), .TAG_W(2 * W)) u_norm_z (
    .clk_i, .rst_ni,
    .in_valid_i (accept),
    .in_vec_i   (dir),
    .in_tag_i   ({eye_y_i, eye_x_i}),
    .out_valid_o(z_valid),
    .unit_o     (z_unit),
    .scaled_o   (),
    .zero_o     (z_zero),
    .tag_o      (z_tag)
  );

  lavm_norm #(.IN_W(W), .FRAC_BITS(FRAC_BITS), .TAG_W(W)) u_norm_u (
    .clk_i, .rst_ni,
    .in_valid_i (accept),
    .in_vec_i   (up_q),
    .in_tag_i   (eye_z_i),
    .out_valid_o(u_valid),
    .unit_o     (u_unit),
    .scaled_o   (u_scaled),
    .zero_o     (u_zero),
    .tag_o      (u_tag)
  );

  // up x Z products
  logic                          c1_v_q;
  logic signed [SCW+UW-1:0]      c1_pp_q [3];
  logic signed [SCW+UW-1:0]      c1_pm_q [3];
  logic [2:0][W-1:0]             c1_az_q, c1_uu_q, c1_eye_q;
  status_e                       c1_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c1_v_q <= 1'b0;
    else         c1_v_q <= z_valid && u_valid;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      c1_pp_q[i] <= $signed(u_scaled[NXT[i]]) * $signed(z_unit[PRV[i]]);
      c1_pm_q[i] <= $signed(u_scaled[PRV[i]]) * $signed(z_unit[NXT[i]]);
      c1_az_q[i] <= sat_w(SW'($signed(z_unit[i])));
      c1_uu_q[i] <= sat_w(SW'($signed(u_unit[i])));
    end
    c1_eye_q <= {u_tag, z_tag};
    if (z_zero)      c1_st_q <= ST_ZERO_DIR;
    else if (u_zero) c1_st_q <= ST_ZERO_UP;
    else             c1_st_q <= ST_OK;
  end

  // X axis normalizer
  logic [2:0][ZXW-1:0] zx;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      zx[i] = ZXW'(SW'(c1_pp_q[i]) - SW'(c1_pm_q[i]));
    end
  end

  logic                x_valid, x_zero;
  logic [2:0][UW-1:0]  x_unit;
  logic [XTW-1:0]      x_tag;
  logic [2:0][W-1:0]   x_eye, x_az, x_uu;
  status_e             x_st;

  lavm_norm #(.IN_W(ZXW), .FRAC_BITS(FRAC_BITS), .TAG_W(XTW)) u_norm_x (
    .clk_i, .rst_ni,
    .in_valid_i (c1_v_q),
    .in_vec_i   (zx),
    .in_tag_i   ({c1_eye_q, c1_az_q, c1_uu_q, c1_st_q}),
    .out_valid_o(x_valid),
    .unit_o     (x_unit),
    .scaled_o   (),
    .zero_o     (x_zero),
    .tag_o      (x_tag)
  );

  assign {x_eye, x_az, x_uu} = x_tag[XTW-1:2];
  assign x_st = status_e'(x_tag[1:0]);

  // Y = Z x X and X x U products
  logic [2:0][W-1:0]         ax_c;
  logic                      y1_v_q;
  logic signed [2*W-1:0]     y1_yp_q [3];
  logic signed [2*W-1:0]     y1_ym_q [3];
  logic signed [2*W-1:0]     y1_bp_q [3];
  logic signed [2*W-1:0]     y1_bm_q [3];
  logic [2:0][W-1:0]         y1_ax_q, y1_az_q, y1_uu_q, y1_eye_q;
  status_e                   y1_st_q;

  always_comb begin
    for (int i = 0; i < 3; i++) ax_c[i] = sat_w(SW'($signed(x_unit[i])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y1_v_q <= 1'b0;
    else         y1_v_q <= x_valid;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      y1_yp_q[i] <= $signed(x_az[NXT[i]]) * $signed(ax_c[PRV[i]]);
      y1_ym_q[i] <= $signed(x_az[PRV[i]]) * $signed(ax_c[NXT[i]]);
      y1_bp_q[i] <= $signed(ax_c[NXT[i]]) * $signed(x_uu[PRV[i]]);
      y1_bm_q[i] <= $signed(ax_c[PRV[i]]) * $signed(x_uu[NXT[i]]);
    end
    y1_ax_q  <= ax_c;
    y1_az_q  <= x_az;
    y1_uu_q  <= x_uu;
    y1_eye_q <= x_eye;
    if (x_st != ST_OK) y1_st_q <= x_st;
    else if (x_zero)   y1_st_q <= ST_PARALLEL;
    else               y1_st_q <= ST_OK;
  end

  logic                y2_v_q;
  logic [2:0][W-1:0]   y2_ax_q, y2_ay_q, y2_az_q, y2_uu_q, y2_zb_q, y2_eye_q;
  status_e             y2_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) y2_v_q <= 1'b0;
    else         y2_v_q <= y1_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      y2_ay_q[i] <= rnd_w(SW'(y1_yp_q[i]) - SW'(y1_ym_q[i]));
      y2_zb_q[i] <= rnd_w(SW'(y1_bp_q[i]) - SW'(y1_bm_q[i]));
    end
    y2_ax_q  <= y1_ax_q;
    y2_az_q  <= y1_az_q;
    y2_uu_q  <= y1_uu_q;
    y2_eye_q <= y1_eye_q;
    y2_st_q  <= y1_st_q;
  end

  // translation products
  logic                   t1_v_q;
  logic signed [2*W-1:0]  t1_p_q [3][3];
  logic [2:0][W-1:0]      t1_ax_q, t1_ay_q, t1_az_q, t1_uu_q, t1_zb_q;
  status_e                t1_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t1_v_q <= 1'b0;
    else         t1_v_q <= y2_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      t1_p_q[0][i] <= $signed(y2_ax_q[i]) * $signed(y2_eye_q[i]);
      t1_p_q[1][i] <= $signed(y2_ay_q[i]) * $signed(y2_eye_q[i]);
      t1_p_q[2][i] <= $signed(y2_az_q[i]) * $signed(y2_eye_q[i]);
    end
    t1_ax_q <= y2_ax_q;
    t1_ay_q <= y2_ay_q;
    t1_az_q <= y2_az_q;
    t1_uu_q <= y2_uu_q;
    t1_zb_q <= y2_zb_q;
    t1_st_q <= y2_st_q;
  end

  logic                   t2_v_q;
  logic signed [2*W+1:0]  t2_s_q [3];
  logic [2:0][W-1:0]      t2_ax_q, t2_ay_q, t2_az_q, t2_uu_q, t2_zb_q;
  status_e                t2_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t2_v_q <= 1'b0;
    else         t2_v_q <= t1_v_q;
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      t2_s_q[a] <= (2*W+2)'(t1_p_q[a][0]) + (2*W+2)'(t1_p_q[a][1]) +
                   (2*W+2)'(t1_p_q[a][2]);
    end
    t2_ax_q <= t1_ax_q;
    t2_ay_q <= t1_ay_q;
    t2_az_q <= t1_az_q;
    t2_uu_q <= t1_uu_q;
    t2_zb_q <= t1_zb_q;
    t2_st_q <= t1_st_q;
  end

  // result buffer and row sequencer
  logic [W-1:0]  b_ax_q [3];
  logic [W-1:0]  b_ay_q [3];
  logic [W-1:0]  b_az_q [3];
  logic [W-1:0]  b_uu_q [3];
  logic [W-1:0]  b_zb_q [3];
  logic [W-1:0]  b_tr_q [3];
  status_e       b_st_q;
  logic          act_q;
  logic [3:0]    cnt_q;

  always_ff @(posedge clk_i) begin
    if (t2_v_q) begin
      for (int i = 0; i < 3; i++) begin
        b_ax_q[i] <= t2_ax_q[i];
        b_ay_q[i] <= t2_ay_q[i];
        b_az_q[i] <= t2_az_q[i];
        b_uu_q[i] <= t2_uu_q[i];
        b_zb_q[i] <= t2_zb_q[i];
        b_tr_q[i] <= rnd_w(-SW'(t2_s_q[i]));
      end
      b_st_q <= t2_st_q;
    end
  end

  logic [W-1:0] sel_x, sel_y, sel_z, sel_w;
  logic [1:0]   ri;

  assign ri = cnt_q[1:0];

  always_comb begin
    sel_x = '0;
    sel_y = '0;
    sel_z = '0;
    sel_w = '0;
    if (ri == 2'd3) begin
      sel_w = ONE;
      if (cnt_q[3:2] == MAT_VIEW) begin
        sel_x = b_tr_q[0];
        sel_y = b_tr_q[1];
        sel_z = b_tr_q[2];
      end
    end else begin
      unique case (cnt_q[3:2])
        MAT_VIEW: begin
          sel_x = b_ax_q[ri];
          sel_y = b_ay_q[ri];
          sel_z = b_az_q[ri];
        end
        MAT_BB_FULL: begin
          unique case (ri)
            2'd0:    {sel_z, sel_y, sel_x} = {b_ax_q[2], b_ax_q[1], b_ax_q[0]};
            2'd1:    {sel_z, sel_y, sel_x} = {b_ay_q[2], b_ay_q[1], b_ay_q[0]};
            default: {sel_z, sel_y, sel_x} = {b_az_q[2], b_az_q[1], b_az_q[0]};
          endcase
        end
        MAT_BB_Y: begin
          unique case (ri)
            2'd0:    {sel_z, sel_y, sel_x} = {b_ax_q[2], b_ax_q[1], b_ax_q[0]};
            2'd1:    {sel_z, sel_y, sel_x} = {b_uu_q[2], b_uu_q[1], b_uu_q[0]};
            default: {sel_z, sel_y, sel_x} = {b_zb_q[2], b_zb_q[1], b_zb_q[0]};
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      cnt_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      valid_o <= act_q;
      if (t2_v_q) begin
        act_q <= 1'b1;
        cnt_q <= '0;
      end else if (act_q) begin
        cnt_q <= cnt_q + 4'd1;
        act_q <= (b_st_q == ST_OK) && (cnt_q != LAST_ROW);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_q) begin
      if (b_st_q != ST_OK) begin
        row_x_o     <= '0;
        row_y_o     <= '0;
        row_z_o     <= '0;
        row_w_o     <= '0;
        matrix_id_o <= MAT_VIEW;
        row_index_o <= '0;
        status_o    <= b_st_q;
        last_o      <= 1'b1;
      end else begin
        row_x_o     <= sel_x;
        row_y_o     <= sel_y;
        row_z_o     <= sel_z;
        row_w_o     <= sel_w;
        matrix_id_o <= cnt_q[3:2];
        row_index_o <= ri;
        status_o    <= ST_OK;
        last_o      <= (cnt_q == LAST_ROW);
      end
    end
  end

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after a transfer in");

  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("result rows broken up");

  a_error_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (last_o && row_index_o == 2'd0 && row_w_o == '0))
    else $error("error row malformed");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t2_v_q |-> (!act_q || cnt_q == LAST_ROW))
    else $error("result buffer overwritten while in use");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o && status_o == ST_OK) |-> (row_index_o == 2'd3 && matrix_id_o == MAT_BB_Y))
    else $error("last flag on wrong row");

endmodule
`default_nettype wire

// File: test/tb_look_at_view_matrix_core.sv
// Self-checking testbench for look_at_view_matrix_core: drives eye/target
// transfers and up-vector writes, predicts in fixed point twelve rows per
// transfer (one if degenerate), checks each strobed row. Uses lavm_pkg.
`default_nettype none
module tb_look_at_view_matrix_core;
  import lavm_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef longint vec3_t [3];
  typedef struct packed {
    logic [CW-1:0] x, y, z, w;
    logic [1:0]    mat, idx, st;
    logic          last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [CW-1:0] cfg_data_i;
  logic start, busy;
  logic [CW-1:0] eye_x_i, eye_y_i, eye_z_i, target_x_i, target_y_i, target_z_i;
  logic valid_o, last_o;
  logic [CW-1:0] row_x_o, row_y_o, row_z_o, row_w_o;
  logic [1:0] matrix_id_o, row_index_o, status_o;

  row_t expected_rows[$];
  logic [CW-1:0] up_vec [3];
  int errors = 0;
  int cycles = 0;

  look_at_view_matrix_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .start, .busy,
    .eye_x_i, .eye_y_i, .eye_z_i, .target_x_i, .target_y_i, .target_z_i,
    .valid_o, .row_x_o, .row_y_o, .row_z_o, .row_w_o, .matrix_id_o,
    .row_index_o, .status_o, .last_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("[look_at_view_matrix_core] ERROR");
      $finish;
    end
  end

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit pow2_scale(input vec3_t v, output vec3_t o);
    longint unsigned m = 0;
    longint unsigned s;
    int sh = 0;
    int ls = 0;
    for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
    if (m == 0) return 1'b0;
    while ((m >> sh) >= (64'h1 << 30)) sh++;
    while (((m >> sh) << ls) < (64'h1 << 29)) ls++;
    for (int i = 0; i < 3; i++) begin
      s = (mag(v[i]) >> sh) << ls;
      o[i] = v[i] < 0 ? -longint'(s) : longint'(s);
    end
    return 1'b1;
  endfunction

  function automatic bit unit_vec(input vec3_t v, output vec3_t o);
    vec3_t c;
    longint unsigned s = 0;
    longint unsigned r, q;
    if (!pow2_scale(v, c)) return 1'b0;
    for (int i = 0; i < 3; i++) s += mag(c[i]) * mag(c[i]);
    r = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ((mag(c[i]) << FB) + (r >> 1)) / r;
      o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  function automatic vec3_t cross_rounded(vec3_t a, vec3_t b);
    vec3_t o = cross3(a, b);
    for (int i = 0; i < 3; i++) o[i] = sat((o[i] + (64'sd1 <<< (FB - 1))) >>> FB);
    return o;
  endfunction

  function automatic logic [CW-1:0] eye_offset(vec3_t a, vec3_t e);
    logic signed [127:0] acc = 0;
    logic signed [127:0] pa, pe;
    for (int i = 0; i < 3; i++) begin
      pa = a[i];
      pe = e[i];
      acc = acc + pa * pe;
    end
    acc = (-acc + (128'sd1 <<< (FB - 1))) >>> FB;
    if (acc > 128'sd2147483647) acc = 128'sd2147483647;
    if (acc < -128'sd2147483648) acc = -128'sd2147483648;
    return acc[CW-1:0];
  endfunction

  task automatic push_row(longint x, longint y, longint z, longint w, logic [1:0] mat,
                          logic [1:0] idx, logic [1:0] st, logic last);
    row_t r;
    r.x = sat(x); r.y = sat(y); r.z = sat(z); r.w = sat(w);
    r.mat = mat; r.idx = idx; r.st = st; r.last = last;
    expected_rows.push_back(r);
  endtask

  task automatic push_view_rows(logic [CW-1:0] eye [3], logic [CW-1:0] tgt [3]);
    vec3_t e, d, up, us, zx, ax, ay, az, uu, zb;
    row_t r;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      e[i] = $signed(eye[i]);
      d[i] = longint'($signed(tgt[i])) - e[i];
      up[i] = $signed(up_vec[i]);
    end
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      push_row(0, 0, 0, 0, MAT_VIEW, 2'd0, ST_ZERO_DIR, 1'b1);
      return;
    end
    if (up[0] == 0 && up[1] == 0 && up[2] == 0) begin
      push_row(0, 0, 0, 0, MAT_VIEW, 2'd0, ST_ZERO_UP, 1'b1);
      return;
    end
    ok = unit_vec(d, az);
    ok = pow2_scale(up, us);
    zx = cross3(us, az);
    if (!unit_vec(zx, ax)) begin
      push_row(0, 0, 0, 0, MAT_VIEW, 2'd0, ST_PARALLEL, 1'b1);
      return;
    end
    for (int i = 0; i < 3; i++) begin
      az[i] = sat(az[i]);
      ax[i] = sat(ax[i]);
    end
    ay = cross_rounded(az, ax);
    ok = unit_vec(up, uu);
    for (int i = 0; i < 3; i++) uu[i] = sat(uu[i]);
    zb = cross_rounded(ax, uu);
    for (int i = 0; i < 3; i++) push_row(ax[i], ay[i], az[i], 0, MAT_VIEW, 2'(i), ST_OK, 0);
    r.x = eye_offset(ax, e); r.y = eye_offset(ay, e); r.z = eye_offset(az, e);
    r.w = 32'h1 << FB; r.mat = MAT_VIEW; r.idx = 2'd3; r.st = ST_OK; r.last = 1'b0;
    expected_rows.push_back(r);
    push_row(ax[0], ax[1], ax[2], 0, MAT_BB_FULL, 2'd0, ST_OK, 0);
    push_row(ay[0], ay[1], ay[2], 0, MAT_BB_FULL, 2'd1, ST_OK, 0);
    push_row(az[0], az[1], az[2], 0, MAT_BB_FULL, 2'd2, ST_OK, 0);
    push_row(0, 0, 0, 64'sd1 <<< FB, MAT_BB_FULL, 2'd3, ST_OK, 0);
    push_row(ax[0], ax[1], ax[2], 0, MAT_BB_Y, 2'd0, ST_OK, 0);
    push_row(uu[0], uu[1], uu[2], 0, MAT_BB_Y, 2'd1, ST_OK, 0);
    push_row(zb[0], zb[1], zb[2], 0, MAT_BB_Y, 2'd2, ST_OK, 0);
    push_row(0, 0, 0, 64'sd1 <<< FB, MAT_BB_Y, 2'd3, ST_OK, 1);
  endtask

  task automatic check_field(string name, logic [CW-1:0] exp_v, logic [CW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    row_t e;
    if (rst_ni && valid_o) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row, expected none, actual %h %h %h %h st %0d", $time,
                 row_x_o, row_y_o, row_z_o, row_w_o, status_o);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        check_field("row_x", e.x, row_x_o);
        check_field("row_y", e.y, row_y_o);
        check_field("row_z", e.z, row_z_o);
        check_field("row_w", e.w, row_w_o);
        check_field("matrix_id", e.mat, matrix_id_o);
        check_field("row_index", e.idx, row_index_o);
        check_field("status", e.st, status_o);
        check_field("last", e.last, last_o);
      end
    end
  end

  task automatic wait_idle();
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_up(cfg_idx_e idx, logic [CW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    up_vec[idx] = value;
  endtask

  task automatic set_up(logic [CW-1:0] ux, logic [CW-1:0] uy, logic [CW-1:0] uz);
    wait_idle();
    write_up(CFG_UP_X, ux);
    write_up(CFG_UP_Y, uy);
    write_up(CFG_UP_Z, uz);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_view(logic [CW-1:0] eye [3], logic [CW-1:0] tgt [3]);
    start <= 1'b1;
    eye_x_i <= eye[0]; eye_y_i <= eye[1]; eye_z_i <= eye[2];
    target_x_i <= tgt[0]; target_y_i <= tgt[1]; target_z_i <= tgt[2];
    do @(posedge clk_i); while (busy);
    push_view_rows(eye, tgt);
  endtask

  task automatic send_pts(logic [CW-1:0] ex, logic [CW-1:0] ey, logic [CW-1:0] ez,
                          logic [CW-1:0] tx, logic [CW-1:0] ty, logic [CW-1:0] tz);
    logic [CW-1:0] e [3];
    logic [CW-1:0] t [3];
    e = '{ex, ey, ez};
    t = '{tx, ty, tz};
    send_view(e, t);
  endtask

  task automatic idle_gap();
    int n;
    int k = $urandom_range(0, 99);
    n = k < 55 ? 0 : (k < 95 ? $urandom_range(1, 4) : $urandom_range(20, 60));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic finish_burst();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] pick_value(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed(32'($urandom_range(0, 32'h01ff_ffff))) - 32'sh0100_0000);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h0;
          1: return 32'h1;
          2: return 32'hffff_ffff;
          3: return 32'h7fff_ffff;
          4: return 32'h8000_0000;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  task automatic test_basic_axes();
    set_up(32'h0, 32'h0001_0000, 32'h0);
    send_pts(0, 0, 0, 0, 0, 32'h0001_0000);
    send_pts(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
             32'hfffb_0000, 32'h0007_0000, 32'h000b_0000);
    idle_gap();
    send_pts(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000);
    send_pts(32'hffff_ffff, 32'h1, 32'h1, 32'h1, 32'hffff_ffff, 32'h0);
    finish_burst();
  endtask

  task automatic test_degenerate();
    set_up(32'h0, 32'h0001_0000, 32'h0);
    send_pts(32'h5_0000, 32'h5_0000, 32'h5_0000, 32'h5_0000, 32'h5_0000, 32'h5_0000);
    send_pts(32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h1_0000, 32'h9_0000, 32'h3_0000);
    send_pts(0, 0, 0, 0, 32'hffff_0000, 0);
    finish_burst();
    set_up(32'h0, 32'h0, 32'h0);
    send_pts(0, 0, 0, 0, 0, 32'h0001_0000);
    send_pts(7, 7, 7, 7, 7, 7);
    finish_burst();
  endtask

  task automatic test_saturation();
    set_up(32'h0, 32'h0001_0000, 32'h0);
    send_pts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_pts(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_pts(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
    finish_burst();
    set_up(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_pts(0, 0, 0, 32'h0001_0000, 0, 0);
    send_pts(32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    finish_burst();
    set_up(32'h8000_0000, 32'h0, 32'h0);
    send_pts(0, 0, 0, 32'h8000_0000, 0, 0);
    send_pts(0, 0, 0, 0, 0, 32'h0000_0001);
    send_pts(32'h8000_0000, 32'h7fff_ffff, 32'h1234_0000, 0, 0, 0);
    finish_burst();
  endtask

  task automatic test_random_views(int count);
    logic [CW-1:0] e [3];
    logic [CW-1:0] t [3];
    int kind;
    int k;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0: set_up($urandom, $urandom, $urandom);
        1: set_up(pick_value(1) >>> 12, pick_value(1) >>> 12, pick_value(1) >>> 12);
        2: set_up(0, pick_value(2), 0);
        default: set_up(pick_value(2), pick_value(2), pick_value(2));
      endcase
      for (int n = 0; n < count / 6; n++) begin
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
          e[i] = pick_value(kind < 3 ? 0 : (kind < 8 ? 1 : 2));
          t[i] = kind < 3 ? $urandom : pick_value(kind < 8 ? 1 : 2);
        end
        if (kind == 0) t = e;
        if (kind == 6 || kind == 7) begin
          k = $urandom_range(1, 8);
          for (int i = 0; i < 3; i++) t[i] = e[i] + up_vec[i] * k;
        end
        if (kind == 8) begin
          t = e;
          t[$urandom_range(0, 2)] = $urandom;
        end
        send_view(e, t);
        idle_gap();
        if (n % 50 == 25) begin
          start <= 1'b0;
          wait_idle();
        end
      end
      finish_burst();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_UP_X;
    cfg_data_i <= '0;
    start <= 1'b0;
    eye_x_i <= '0; eye_y_i <= '0; eye_z_i <= '0;
    target_x_i <= '0; target_y_i <= '0; target_z_i <= '0;
    up_vec = '{32'h0, 32'h0001_0000, 32'h0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_axes();
    test_degenerate();
    test_saturation();
    test_random_views(360);
    wait_idle();
    repeat (2 * FB + 100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[look_at_view_matrix_core] OK");
    end else begin
      $display("[look_at_view_matrix_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: look_at_view_matrix_core.f
sv/lavm_pkg.sv
sv/lavm_norm.sv
sv/look_at_view_matrix_core.sv
test/tb_look_at_view_matrix_core.sv
